@@ hw/rtl/u8san_pkg.sv @@
// shared types, constants and byte classification for the utf-8 sanitizer
package u8san_pkg;

    // replacement character U+FFFD as utf-8
    localparam logic [7:0] REP_BYTE0 = 8'hEF;
    localparam logic [7:0] REP_BYTE1 = 8'hBF;
    localparam logic [7:0] REP_BYTE2 = 8'hBD;
    localparam logic [1:0] REP_PHASE_LAST = 2'd2;

    // byte classes
    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;
    localparam logic [7:0] LEAD2_MIN = 8'hC2;
    localparam logic [7:0] LEAD3_MIN = 8'hE0;
    localparam logic [7:0] LEAD4_MIN = 8'hF0;
    localparam logic [7:0] LEAD_END  = 8'hF5;

    // leads whose first continuation has a narrowed range
    localparam logic [7:0] LEAD_E0 = 8'hE0;
    localparam logic [7:0] LEAD_ED = 8'hED;
    localparam logic [7:0] LEAD_F0 = 8'hF0;
    localparam logic [7:0] LEAD_F4 = 8'hF4;
    localparam logic [7:0] CONT_A0 = 8'hA0;
    localparam logic [7:0] CONT_9F = 8'h9F;
    localparam logic [7:0] CONT_90 = 8'h90;
    localparam logic [7:0] CONT_8F = 8'h8F;

    // command queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // one command: rep_count replacements, then lit_count literal bytes
    typedef struct packed {
        logic            last;
        logic [2:0]      rep_count;
        logic [2:0]      lit_count;
        logic [3:0][7:0] lit;
    } cmd_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] follow;
    } lead_t;

    function automatic logic is_cont(input logic [7:0] b);
        return (b & CONT_MASK) == CONT_TAG;
    endfunction

    function automatic lead_t lead_class(input logic [7:0] b);
        lead_t r;
        r.valid  = 1'b1;
        r.follow = 2'd0;
        priority if (b < CONT_TAG)
        begin
            r.follow = 2'd0;
        end
        else if (b >= LEAD2_MIN && b < LEAD3_MIN)
        begin
            r.follow = 2'd1;
        end
        else if (b >= LEAD3_MIN && b < LEAD4_MIN)
        begin
            r.follow = 2'd2;
        end
        else if (b >= LEAD4_MIN && b < LEAD_END)
        begin
            r.follow = 2'd3;
        end
        else
        begin
            r.valid = 1'b0;
        end
        return r;
    endfunction

    function automatic logic first_ok(input logic [7:0] lead, input logic [7:0] c);
        logic r;
        r = is_cont(c);
        priority if (lead == LEAD_E0)
        begin
            r = r && (c >= CONT_A0);
        end
        else if (lead == LEAD_ED)
        begin
            r = r && (c <= CONT_9F);
        end
        else if (lead == LEAD_F0)
        begin
            r = r && (c >= CONT_90);
        end
        else if (lead == LEAD_F4)
        begin
            r = r && (c <= CONT_8F);
        end
        else
        begin
            r = r;
        end
        return r;
    endfunction

    function automatic logic [7:0] rep_byte(input logic [1:0] phase);
        logic [7:0] r;
        unique case (phase)
            2'd0:    r = REP_BYTE0;
            2'd1:    r = REP_BYTE1;
            default: r = REP_BYTE2;
        endcase
        return r;
    endfunction

endpackage

@@ hw/rtl/u8san_in_if.sv @@
// raw byte channel with last flag
interface u8san_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

@@ hw/rtl/u8san_out_if.sv @@
// sanitized byte channel with last flag
interface u8san_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

@@ hw/rtl/u8san_front.sv @@
// front: accepts raw bytes, tracks the pending sequence, issues output commands
module u8san_front
    import u8san_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    u8san_in_if.sink     raw,
    input  logic         q_full,
    output logic         cmd_push,
    output cmd_t         cmd
);

    logic [1:0] held_count_reg, held_count_next;
    logic [1:0] needed_reg, needed_next;
    logic [7:0] held_reg [3];
    logic [7:0] held_next [3];

    lead_t           lc;
    logic            ok;
    logic            start;
    logic            accept;
    logic [2:0]      rep;
    logic [2:0]      lit_n;
    logic [3:0][7:0] lit;

    assign raw.ready = !q_full;
    assign accept    = raw.valid && raw.ready;

    always_comb
    begin
        held_count_next = held_count_reg;
        needed_next     = needed_reg;
        held_next       = held_reg;
        rep             = 3'd0;
        lit_n           = 3'd0;
        lit[0]          = held_reg[0];
        lit[1]          = held_reg[1];
        lit[2]          = held_reg[2];
        lit[3]          = raw.in_byte;
        start           = 1'b0;
        lc              = lead_class(raw.in_byte);
        ok              = (held_count_reg == 2'd1) ? first_ok(held_reg[0], raw.in_byte)
                                                   : is_cont(raw.in_byte);

        if (held_count_reg == 2'd0)
        begin
            start = 1'b1;
        end
        else if (ok)
        begin
            if (held_count_reg >= needed_reg)
            begin
                // sequence complete: pass held bytes and this one through
                lit_n               = {1'b0, held_count_reg} + 3'd1;
                lit[held_count_reg] = raw.in_byte;
                held_count_next     = 2'd0;
                needed_next         = 2'd0;
            end
            else
            begin
                if (held_count_reg == 2'd1)
                begin
                    held_next[1] = raw.in_byte;
                end
                else
                begin
                    held_next[2] = raw.in_byte;
                end
                held_count_next = held_count_reg + 2'd1;
            end
        end
        else
        begin
            // bad continuation: replace each held byte, rescan this one
            rep             = {1'b0, held_count_reg};
            held_count_next = 2'd0;
            needed_next     = 2'd0;
            start           = 1'b1;
        end

        if (start)
        begin
            if (!lc.valid)
            begin
                rep = rep + 3'd1;
            end
            else if (lc.follow == 2'd0)
            begin
                lit_n  = 3'd1;
                lit[0] = raw.in_byte;
            end
            else
            begin
                held_next[0]    = raw.in_byte;
                held_count_next = 2'd1;
                needed_next     = lc.follow;
            end
        end

        // end of string flushes whatever is still pending
        if (raw.in_last)
        begin
            rep             = rep + {1'b0, held_count_next};
            held_count_next = 2'd0;
            needed_next     = 2'd0;
        end
    end

    assign cmd_push      = accept && ((rep != 3'd0) || (lit_n != 3'd0));
    assign cmd.last      = raw.in_last;
    assign cmd.rep_count = rep;
    assign cmd.lit_count = lit_n;
    assign cmd.lit       = lit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= 2'd0;
            needed_reg     <= 2'd0;
        end
        else if (accept)
        begin
            held_count_reg <= held_count_next;
            needed_reg     <= needed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held_reg <= held_next;
        end
    end

    a_held_within_needed: assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg != 2'd0 |-> held_count_reg <= needed_reg)
        else $error("held count exceeded needed total");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && raw.in_last |=> held_count_reg == 2'd0)
        else $error("state not clear after last byte");

    a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
        accept && raw.in_last |-> cmd_push)
        else $error("last byte produced no output");

endmodule

@@ hw/rtl/u8san_queue.sv @@
// short command queue decoupling front and back
module u8san_queue
    import u8san_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t wr_data,
    output logic full,
    input  logic pop,
    output cmd_t rd_data,
    output logic empty
);

    cmd_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    assign full    = count_reg == QCNT_W'(QDEPTH);
    assign empty   = count_reg == '0;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

endmodule

@@ hw/rtl/u8san_back.sv @@
// back: expands commands into output beats through an output register
module u8san_back
    import u8san_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cmd_t         cmd,
    input  logic         cmd_valid,
    output logic         cmd_pop,
    u8san_out_if.source  clean
);

    logic [2:0] rep_done_reg, rep_done_next;
    logic [1:0] phase_reg, phase_next;
    logic [1:0] lit_idx_reg, lit_idx_next;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;

    logic       in_rep;
    logic       final_beat;
    logic       advance;
    logic [7:0] cur_byte;

    assign in_rep   = rep_done_reg < cmd.rep_count;
    assign cur_byte = in_rep ? rep_byte(phase_reg) : cmd.lit[lit_idx_reg];
    assign final_beat = in_rep ?
        (phase_reg == REP_PHASE_LAST && rep_done_reg + 3'd1 == cmd.rep_count
         && cmd.lit_count == 3'd0) :
        ({1'b0, lit_idx_reg} + 3'd1 == cmd.lit_count);
    assign advance  = cmd_valid && (!out_valid_reg || clean.ready);
    assign cmd_pop  = advance && final_beat;

    always_comb
    begin
        rep_done_next = rep_done_reg;
        phase_next    = phase_reg;
        lit_idx_next  = lit_idx_reg;
        if (advance)
        begin
            if (final_beat)
            begin
                rep_done_next = 3'd0;
                phase_next    = 2'd0;
                lit_idx_next  = 2'd0;
            end
            else if (in_rep)
            begin
                if (phase_reg == REP_PHASE_LAST)
                begin
                    phase_next    = 2'd0;
                    rep_done_next = rep_done_reg + 3'd1;
                end
                else
                begin
                    phase_next = phase_reg + 2'd1;
                end
            end
            else
            begin
                lit_idx_next = lit_idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rep_done_reg  <= 3'd0;
            phase_reg     <= 2'd0;
            lit_idx_reg   <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rep_done_reg <= rep_done_next;
            phase_reg    <= phase_next;
            lit_idx_reg  <= lit_idx_next;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (clean.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg <= cur_byte;
            out_last_reg <= cmd.last && final_beat;
        end
    end

    assign clean.valid    = out_valid_reg;
    assign clean.out_byte = out_byte_reg;
    assign clean.out_last = out_last_reg;

    a_partial_keeps_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !final_beat |=> cmd_valid)
        else $error("command vanished mid expansion");

endmodule

@@ hw/rtl/utf8_byte_stream_sanitizer_unit.sv @@
// top level of the utf-8 byte stream sanitizer
//
// channel   dir   beat payload         meaning
// raw       in    in_byte, in_last     raw bytes, last marks end of string
// clean     out   out_byte, out_last   sanitized utf-8, last on final byte
//
// one raw beat is taken per cycle while the command queue has room
// each raw beat yields 0 to 12 clean beats, sent one per cycle by the back end while clean is ready
// valid text sustains one byte per cycle while clean is ready; a malformed run sends three
//   bytes per replacement character through the one-byte-wide output register
// asynchronous active-low reset clears the held sequence, queue and output valid
// stalls on clean back up into the queue and then drop raw ready
module utf8_byte_stream_sanitizer_unit
    import u8san_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    u8san_in_if.sink     raw,
    u8san_out_if.source  clean
);

    // front to queue
    cmd_t push_cmd;
    logic push;
    logic q_full;

    // queue to back
    cmd_t head_cmd;
    logic q_empty;
    logic pop;

    // classification and sequence tracking, one beat per cycle while the queue has room
    u8san_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .raw      (raw),
        .q_full   (q_full),
        .cmd_push (push),
        .cmd      (push_cmd)
    );

    // decouples the input handshake from output expansion
    u8san_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (push_cmd),
        .full    (q_full),
        .pop     (pop),
        .rd_data (head_cmd),
        .empty   (q_empty)
    );

    // expands replacements and literal bytes into clean beats
    u8san_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (head_cmd),
        .cmd_valid (!q_empty),
        .cmd_pop   (pop),
        .clean     (clean)
    );

endmodule

@@ verif/tb_utf8_byte_stream_sanitizer_unit.sv @@
// self-checking testbench for the utf-8 byte stream sanitizer top level
module tb_utf8_byte_stream_sanitizer_unit;
    import u8san_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // byte range bounds used by the generator and the predictor
    localparam logic [7:0] ASCII_MAX = 8'h7F;
    localparam logic [7:0] CONT_MAX  = 8'hBF;
    localparam logic [7:0] LEAD2_MAX = 8'hDF;
    localparam logic [7:0] LEAD3_MAX = 8'hEF;
    localparam logic [7:0] LEAD4_MAX = 8'hF4;
    localparam logic [7:0] BYTE_C0   = 8'hC0;
    localparam logic [7:0] BYTE_MAX  = 8'hFF;

    // typed expectations for the directed table
    localparam logic [2:0][7:0] REP_SEQ  = {REP_BYTE2, REP_BYTE1, REP_BYTE0};
    localparam logic [2:0][7:0] NO_BYTES = '0;

    localparam int RAND_ITEMS = 190;
    localparam int DRAIN_WAIT = 20;
    // quiet cycles tolerated before the run is declared hung
    localparam int QUIET_LIMIT = 2000;

    // one clean beat as the predictor expects it
    typedef struct {
        logic [7:0] data;
        logic       last;
    } clean_beat_t;

    // one raw beat of stimulus
    typedef struct {
        logic [7:0] data;
        logic       last;
    } raw_beat_t;

    // directed row: when typed is set, n bytes of e replace the prediction
    typedef struct packed {
        logic [7:0]      b;
        logic            l;
        logic            typed;
        logic [1:0]      n;
        logic [2:0][7:0] e;
    } dir_row_t;

    localparam int DIR_N = 26;

    dir_row_t dir_tab [0:DIR_N-1] = '{
        // extremes of the ascii range, right after reset
        '{8'h00, 1'b0, 1'b1, 2'd1, NO_BYTES},
        '{8'h7F, 1'b0, 1'b1, 2'd1, {8'h00, 8'h00, 8'h7F}},
        // invalid leads: a stray continuation, overlong c1, above f4, ff
        '{8'h80, 1'b0, 1'b1, 2'd3, REP_SEQ},
        '{8'hC1, 1'b0, 1'b1, 2'd3, REP_SEQ},
        '{8'hF5, 1'b0, 1'b1, 2'd3, REP_SEQ},
        '{8'hFF, 1'b0, 1'b1, 2'd3, REP_SEQ},
        // two-byte lead is held, nothing comes out yet
        '{8'hC2, 1'b0, 1'b1, 2'd0, NO_BYTES},
        '{8'h80, 1'b0, 1'b0, 2'd0, NO_BYTES},
        // narrowed first continuation after e0, ed, f0, f4: each one broken
        '{8'hE0, 1'b0, 1'b0, 2'd0, NO_BYTES},
        '{8'h9F, 1'b0, 1'b0, 2'd0, NO_BYTES},
        '{8'hED, 1'b0, 1'b0, 2'd0, NO_BYTES},
        '{8'hA0, 1'b0, 1'b0, 2'd0, NO_BYTES},
        '{8'hF0, 1'b0, 1'b0, 2'd0, NO_BYTES},
        '{8'h8F, 1'b0, 1'b0, 2'd0, NO_BYTES},
        '{8'hF4, 1'b0, 1'b0, 2'd0, NO_BYTES},
        '{8'h90, 1'b0, 1'b0, 2'd0, NO_BYTES},
        // highest four-byte code point passes through
        '{8'hF4, 1'b0, 1'b0, 2'd0, NO_BYTES},
        '{8'h8F, 1'b0, 1'b0, 2'd0, NO_BYTES},
        '{8'hBF, 1'b0, 1'b0, 2'd0, NO_BYTES},
        '{8'hBF, 1'b0, 1'b0, 2'd0, NO_BYTES},
        // end of string on a plain byte, then on a lone lead
        '{8'h41, 1'b1, 1'b1, 2'd1, {8'h00, 8'h00, 8'h41}},
        '{8'hE1, 1'b1, 1'b1, 2'd3, REP_SEQ},
        // three held bytes broken by a lead on the last beat: twelve out
        '{8'hF1, 1'b0, 1'b0, 2'd0, NO_BYTES},
        '{8'h80, 1'b0, 1'b0, 2'd0, NO_BYTES},
        '{8'h80, 1'b0, 1'b0, 2'd0, NO_BYTES},
        '{8'hC2, 1'b1, 1'b0, 2'd0, NO_BYTES}
    };

    // idling per phase: none, sender, receiver, both lightly
    int src_pct_tab [0:3] = '{0, 76, 0, 10};
    int snk_pct_tab [0:3] = '{0, 0, 76, 10};

    logic clk = 1'b0;
    logic rst_n;

    u8san_in_if  raw_if ();
    u8san_out_if clean_if ();

    utf8_byte_stream_sanitizer_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .raw   (raw_if),
        .clean (clean_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int err_count     = 0;
    int quiet_cycles  = 0;

    // clean beats still owed by the block, oldest first
    clean_beat_t pending_clean_q [$];
    raw_beat_t   raw_stim_q [$];
    logic [7:0]  str_q [$];

    // sanitizer state as the predictor tracks it
    logic [7:0]  held [0:2];
    int          held_n = 0;
    int          need_n = 0;

    // beats caused by the current raw beat
    clean_beat_t step_buf [0:11];
    int          step_n;

    function automatic void emit_byte(logic [7:0] b);
        step_buf[step_n].data = b;
        step_buf[step_n].last = 1'b0;
        step_n++;
    endfunction

    function automatic void emit_rep();
        emit_byte(REP_BYTE0);
        emit_byte(REP_BYTE1);
        emit_byte(REP_BYTE2);
    endfunction

    // every held byte turns into one replacement character
    function automatic void flush_held();
        int i;
        for (i = 0; i < held_n; i++)
        begin
            emit_rep();
        end
        held_n = 0;
        need_n = 0;
    endfunction

    // a byte seen with nothing held: ascii, a new lead, or junk
    function automatic void start_seq(logic [7:0] b);
        if (b <= ASCII_MAX)
        begin
            emit_byte(b);
        end
        else if (b >= LEAD2_MIN && b < LEAD_END)
        begin
            held[0] = b;
            held_n  = 1;
            need_n  = (b < LEAD3_MIN) ? 1 : (b < LEAD4_MIN) ? 2 : 3;
        end
        else
        begin
            emit_rep();
        end
    endfunction

    function automatic logic first_cont_ok(logic [7:0] lead, logic [7:0] c);
        if (c[7:6] != 2'b10)
        begin
            return 1'b0;
        end
        case (lead)
            LEAD_E0: return c >= CONT_A0;
            LEAD_ED: return c <= CONT_9F;
            LEAD_F0: return c >= CONT_90;
            LEAD_F4: return c <= CONT_8F;
            default: return 1'b1;
        endcase
    endfunction

    // fills step_buf with the clean beats one raw beat causes
    function automatic void sanitize_byte(logic [7:0] b, logic l);
        logic ok;
        int   i;
        step_n = 0;
        if (held_n == 0)
        begin
            start_seq(b);
        end
        else
        begin
            ok = (held_n == 1) ? first_cont_ok(held[0], b) : (b[7:6] == 2'b10);
            if (ok && held_n >= need_n)
            begin
                // sequence complete: pass it through untouched
                for (i = 0; i < held_n; i++)
                begin
                    emit_byte(held[i]);
                end
                emit_byte(b);
                held_n = 0;
                need_n = 0;
            end
            else if (ok)
            begin
                held[held_n] = b;
                held_n++;
            end
            else
            begin
                // broken sequence, then the offending byte starts afresh
                flush_held();
                start_seq(b);
            end
        end
        if (l)
        begin
            flush_held();
        end
    endfunction

    // appends one well-formed sequence of len bytes, biased to the edge leads
    function automatic void add_valid(int len);
        logic [7:0] lead;
        logic [7:0] lo;
        logic [7:0] hi;
        case (len)
            1: str_q.push_back(8'($urandom_range(0, ASCII_MAX)));
            2:
            begin
                str_q.push_back(8'($urandom_range(LEAD2_MIN, LEAD2_MAX)));
                str_q.push_back(8'($urandom_range(CONT_TAG, CONT_MAX)));
            end
            default:
            begin
                if (len == 3)
                begin
                    lead = ($urandom_range(0, 2) == 0)
                         ? (($urandom_range(0, 1) == 0) ? LEAD_E0 : LEAD_ED)
                         : 8'($urandom_range(LEAD3_MIN, LEAD3_MAX));
                end
                else
                begin
                    lead = ($urandom_range(0, 2) == 0)
                         ? (($urandom_range(0, 1) == 0) ? LEAD_F0 : LEAD_F4)
                         : 8'($urandom_range(LEAD4_MIN, LEAD4_MAX));
                end
                lo = CONT_TAG;
                hi = CONT_MAX;
                case (lead)
                    LEAD_E0: lo = CONT_A0;
                    LEAD_ED: hi = CONT_9F;
                    LEAD_F0: lo = CONT_90;
                    LEAD_F4: hi = CONT_8F;
                    default: ;
                endcase
                str_q.push_back(lead);
                str_q.push_back(8'($urandom_range(lo, hi)));
                repeat (len - 2)
                begin
                    str_q.push_back(8'($urandom_range(CONT_TAG, CONT_MAX)));
                end
            end
        endcase
    endfunction

    // one random string: mostly well-formed characters, some junk
    function automatic void add_string();
        int r;
        int len;
        int i;
        str_q.delete();
        repeat ($urandom_range(1, 8))
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
            begin
                add_valid(1);
            end
            else if (r < 50)
            begin
                add_valid(2);
            end
            else if (r < 68)
            begin
                add_valid(3);
            end
            else if (r < 82)
            begin
                add_valid(4);
            end
            else if (r < 88)
            begin
                // plain noise
                str_q.push_back(8'($urandom_range(0, BYTE_MAX)));
            end
            else if (r < 94)
            begin
                // truncated sequence
                len = $urandom_range(2, 4);
                add_valid(len);
                repeat ($urandom_range(1, len - 1))
                begin
                    void'(str_q.pop_back());
                end
            end
            else
            begin
                // first continuation just outside the allowed window
                case ($urandom_range(0, 4))
                    0:
                    begin
                        str_q.push_back(LEAD_E0);
                        str_q.push_back(8'($urandom_range(CONT_TAG, CONT_9F)));
                    end
                    1:
                    begin
                        str_q.push_back(LEAD_ED);
                        str_q.push_back(8'($urandom_range(CONT_A0, CONT_MAX)));
                    end
                    2:
                    begin
                        str_q.push_back(LEAD_F0);
                        str_q.push_back(8'($urandom_range(CONT_TAG, CONT_8F)));
                    end
                    3:
                    begin
                        str_q.push_back(LEAD_F4);
                        str_q.push_back(8'($urandom_range(CONT_90, CONT_MAX)));
                    end
                    default:
                    begin
                        // any lead followed by a byte that is no continuation
                        str_q.push_back(8'($urandom_range(LEAD2_MIN, LEAD4_MAX)));
                        str_q.push_back(($urandom_range(0, 1) == 0)
                            ? 8'($urandom_range(0, ASCII_MAX))
                            : 8'($urandom_range(BYTE_C0, BYTE_MAX)));
                    end
                endcase
            end
        end
        for (i = 0; i < str_q.size(); i++)
        begin
            raw_stim_q.push_back('{str_q[i], (i == str_q.size() - 1)});
        end
    endfunction

    // drives one raw beat, waits for it to be taken, then records what it owes
    task automatic send_byte(logic [7:0] b, logic l, logic typed, logic [1:0] n,
                             logic [2:0][7:0] e);
        int i;
        // random sender gaps before the beat is offered
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            raw_if.valid <= 1'b0;
            @(posedge clk);
        end
        raw_if.valid   <= 1'b1;
        raw_if.in_byte <= b;
        raw_if.in_last <= l;
        do
        begin
            @(posedge clk);
        end
        while (!raw_if.ready);
        // the beat went in at this edge
        sanitize_byte(b, l);
        if (typed)
        begin
            step_n = n;
            for (i = 0; i < n; i++)
            begin
                step_buf[i].data = e[i];
            end
        end
        for (i = 0; i < step_n; i++)
        begin
            pending_clean_q.push_back('{step_buf[i].data, l && (i == step_n - 1)});
        end
    endtask

    // clean side: check each beat against the oldest owed one, then stall at random
    always @(posedge clk)
    begin
        clean_beat_t want;
        if (rst_n && clean_if.valid && clean_if.ready)
        begin
            if (pending_clean_q.size() == 0)
            begin
                if (err_count < 10)
                begin
                    $display("unexpected clean beat: got %h last %b",
                             clean_if.out_byte, clean_if.out_last);
                end
                err_count++;
            end
            else
            begin
                want = pending_clean_q.pop_front();
                if (clean_if.out_byte !== want.data || clean_if.out_last !== want.last)
                begin
                    if (err_count < 10)
                    begin
                        $display("clean beat mismatch: expected %h last %b, got %h last %b",
                                 want.data, want.last, clean_if.out_byte,
                                 clean_if.out_last);
                    end
                    err_count++;
                end
            end
        end
        clean_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    // watchdog: too long without any beat on either channel means a hang
    always @(posedge clk)
    begin
        if (!rst_n || (raw_if.valid && raw_if.ready) || (clean_if.valid && clean_if.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb_utf8_byte_stream_sanitizer_unit: done, errors");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int k;
        int ph;
        int total;
        rst_n           = 1'b0;
        raw_if.valid    = 1'b0;
        raw_if.in_byte  = '0;
        raw_if.in_last  = 1'b0;
        clean_if.ready  = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed table, no idling
        for (k = 0; k < DIR_N; k++)
        begin
            send_byte(dir_tab[k].b, dir_tab[k].l, dir_tab[k].typed, dir_tab[k].n,
                      dir_tab[k].e);
        end

        while (raw_stim_q.size() < RAND_ITEMS)
        begin
            add_string();
        end
        total = raw_stim_q.size();

        // random strings in four idling phases
        for (ph = 0; ph < 4; ph++)
        begin
            // sender holds off until every owed beat has drained
            raw_if.valid <= 1'b0;
            @(posedge clk);
            while (pending_clean_q.size() != 0)
            begin
                @(posedge clk);
            end
            src_idle_pct  = src_pct_tab[ph];
            snk_stall_pct = snk_pct_tab[ph];
            for (k = ph * total / 4; k < (ph + 1) * total / 4; k++)
            begin
                send_byte(raw_stim_q[k].data, raw_stim_q[k].last, 1'b0, 2'd0, NO_BYTES);
            end
        end

        raw_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_clean_q.size() != 0)
        begin
            @(posedge clk);
        end
        // catch any stray beat after the last owed one
        repeat (DRAIN_WAIT) @(posedge clk);

        if (err_count == 0 && pending_clean_q.size() == 0)
        begin
            $display("tb_utf8_byte_stream_sanitizer_unit: done, clean");
        end
        else
        begin
            $display("tb_utf8_byte_stream_sanitizer_unit: done, errors");
        end
        $finish;
    end

endmodule
